// File: sv/frustum_box_point_cull_core_assert.svh
// assertion macros for the frustum culling core
`ifndef FRUSTUM_BOX_POINT_CULL_CORE_ASSERT_SVH
`define FRUSTUM_BOX_POINT_CULL_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FBPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpc assertion failed");

// next-cycle implication, disabled in reset
`define FBPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpc assertion failed");

`endif

// File: sv/fbpc_pkg.sv
// shared constants for the frustum culling core
`default_nettype none

package fbpc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int COORD_BITS  = 32;

    localparam int PLANE_IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int SLOT_W      = 3;
    localparam int CMD_W       = 2;
    localparam int PROD_W      = 2 * COORD_BITS;
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_BITS   = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOX   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POINT = 2'd2;

    localparam logic [1:0] TERM_X   = 2'd0;
    localparam logic [1:0] TERM_Y   = 2'd1;
    localparam logic [1:0] TERM_Z   = 2'd2;
    localparam logic [1:0] TERM_OFS = 2'd3;

endpackage

`default_nettype wire

// File: sv/fbpc_if.sv
// command and result channel interfaces
`default_nettype none

interface fbpc_cmd_if import fbpc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             command;
    logic [SLOT_W-1:0]            plane_slot;
    logic signed [COORD_BITS-1:0] normal_x;
    logic signed [COORD_BITS-1:0] normal_y;
    logic signed [COORD_BITS-1:0] normal_z;
    logic signed [COORD_BITS-1:0] plane_offset;
    logic signed [COORD_BITS-1:0] lo_x;
    logic signed [COORD_BITS-1:0] lo_y;
    logic signed [COORD_BITS-1:0] lo_z;
    logic signed [COORD_BITS-1:0] hi_x;
    logic signed [COORD_BITS-1:0] hi_y;
    logic signed [COORD_BITS-1:0] hi_z;

    modport source (
        output valid, command, plane_slot, normal_x, normal_y, normal_z, plane_offset,
        output lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
        input  ready
    );
    modport sink (
        input  valid, command, plane_slot, normal_x, normal_y, normal_z, plane_offset,
        input  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
        output ready
    );
endinterface

interface fbpc_res_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

// File: sv/frustum_box_point_cull_core.sv
// frustum culling core: plane store, shared multiplier and test sequencer
`default_nettype none
`include "frustum_box_point_cull_core_assert.svh"

// Frustum culling engine with PLANE_COUNT stored planes in signed Q16.16. A load
// command writes one plane in the cycle it is accepted and gives no result; a load to
// a slot at or beyond PLANE_COUNT, and command code 3, are dropped. A box or point
// test gives one visible bit: for each plane the box corner farthest along the normal
// is chosen and its exact signed distance is summed in a wide accumulator; the item is
// culled if any distance is negative. A test handles one term per cycle, four terms
// per plane (x, y, z through one shared 32x32 multiplier, then the offset scaled by
// 2^16); the result is handed over once the output register is free or its previous
// result is being taken. cmd.ready is low while a test runs and returns with the
// result. A finished result waits in an output register, and new commands are taken
// meanwhile.
module frustum_box_point_cull_core
    import fbpc_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    fbpc_cmd_if.sink      cmd,
    fbpc_res_if.source    res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // plane store
    logic signed [COORD_BITS-1:0] nx_reg  [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] ny_reg  [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] nz_reg  [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] ofs_reg [PLANE_COUNT];

    // latched test operands
    logic signed [COORD_BITS-1:0] lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [COORD_BITS-1:0] hi_x_reg, hi_y_reg, hi_z_reg;
    logic                         box_reg;

    logic [1:0]             state_reg, state_next;
    logic [1:0]             term_reg, term_next;
    logic [PLANE_IDX_W-1:0] plane_reg, plane_next;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     prod_vld_reg, prod_vld_next;
    logic                     prod_last_reg, prod_last_next;
    logic                     prod_final_reg, prod_final_next;

    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_sum;
    logic                    culled_reg, culled_next;

    logic out_valid_reg, out_valid_next;
    logic vis_reg, vis_next;

    logic                         in_xfer, test_xfer, load_xfer, out_xfer;
    logic                         plane_last;
    logic signed [COORD_BITS-1:0] mul_a, mul_b, sel_lo, sel_hi, ofs_sel;
    logic signed [PROD_W-1:0]     mul_prod;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign in_xfer    = cmd.valid && cmd.ready;
    assign load_xfer  = in_xfer && (cmd.command == CMD_LOAD);
    assign test_xfer  = in_xfer && ((cmd.command == CMD_BOX) || (cmd.command == CMD_POINT));
    assign out_xfer   = res.valid && res.ready;
    assign res.valid  = out_valid_reg;
    assign res.visible = vis_reg;

    assign plane_last = (plane_reg == PLANE_IDX_W'(PLANE_COUNT - 1));
    assign ofs_sel    = ofs_reg[plane_reg];

    // operand select: normal component and farthest corner coordinate
    always_comb
    begin
        unique case (term_reg)
            TERM_X:
            begin
                mul_a  = nx_reg[plane_reg];
                sel_lo = lo_x_reg;
                sel_hi = hi_x_reg;
            end
            TERM_Y:
            begin
                mul_a  = ny_reg[plane_reg];
                sel_lo = lo_y_reg;
                sel_hi = hi_y_reg;
            end
            default:
            begin
                mul_a  = nz_reg[plane_reg];
                sel_lo = lo_z_reg;
                sel_hi = hi_z_reg;
            end
        endcase
        mul_b = (box_reg && !mul_a[COORD_BITS-1]) ? sel_hi : sel_lo;
    end

    // full signed product, operands sign extended by the assignment width
    assign mul_prod = mul_a * mul_b;

    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    always_comb
    begin
        state_next      = state_reg;
        term_next       = term_reg;
        plane_next      = plane_reg;
        prod_next       = prod_reg;
        prod_vld_next   = 1'b0;
        prod_last_next  = 1'b0;
        prod_final_next = 1'b0;
        acc_next        = acc_reg;
        culled_next     = culled_reg;
        out_valid_next  = out_valid_reg && !out_xfer;
        vis_next        = vis_reg;

        // accumulate stage
        if (prod_vld_reg)
        begin
            if (prod_last_reg)
            begin
                if (acc_sum[ACC_W-1])
                begin
                    culled_next = 1'b1;
                end
                acc_next = '0;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (test_xfer)
                begin
                    state_next  = ST_RUN;
                    term_next   = TERM_X;
                    plane_next  = '0;
                    acc_next    = '0;
                    culled_next = 1'b0;
                end
            end
            ST_RUN:
            begin
                // one term a cycle: a shared multiplier product or the scaled offset
                if (term_reg == TERM_OFS)
                begin
                    prod_next = {{(PROD_W - COORD_BITS - FRAC_BITS){ofs_sel[COORD_BITS-1]}},
                                 ofs_sel, {FRAC_BITS{1'b0}}};
                end
                else
                begin
                    prod_next = mul_prod;
                end
                prod_vld_next   = 1'b1;
                prod_last_next  = (term_reg == TERM_OFS);
                prod_final_next = (term_reg == TERM_OFS) && plane_last;
                term_next       = term_reg + 2'd1;
                if (term_reg == TERM_OFS)
                begin
                    if (plane_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        plane_next = plane_reg + PLANE_IDX_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (prod_vld_reg && prod_final_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    vis_next       = !culled_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            term_reg       <= TERM_X;
            plane_reg      <= '0;
            prod_vld_reg   <= 1'b0;
            prod_last_reg  <= 1'b0;
            prod_final_reg <= 1'b0;
            culled_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                nx_reg[i]  <= '0;
                ny_reg[i]  <= '0;
                nz_reg[i]  <= '0;
                ofs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            term_reg       <= term_next;
            plane_reg      <= plane_next;
            prod_vld_reg   <= prod_vld_next;
            prod_last_reg  <= prod_last_next;
            prod_final_reg <= prod_final_next;
            culled_reg     <= culled_next;
            out_valid_reg  <= out_valid_next;
            if (load_xfer)
            begin
                for (int i = 0; i < PLANE_COUNT; i++)
                begin
                    if (32'(cmd.plane_slot) == i)
                    begin
                        nx_reg[i]  <= cmd.normal_x;
                        ny_reg[i]  <= cmd.normal_y;
                        nz_reg[i]  <= cmd.normal_z;
                        ofs_reg[i] <= cmd.plane_offset;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        vis_reg  <= vis_next;
        if (test_xfer)
        begin
            lo_x_reg <= cmd.lo_x;
            lo_y_reg <= cmd.lo_y;
            lo_z_reg <= cmd.lo_z;
            hi_x_reg <= cmd.hi_x;
            hi_y_reg <= cmd.hi_y;
            hi_z_reg <= cmd.hi_z;
            box_reg  <= (cmd.command == CMD_BOX);
        end
    end

    `FBPC_ASSERT_NEXT(a_test_starts, clk, rst_n, test_xfer,
        (state_reg == ST_RUN) && (term_reg == TERM_X) && (plane_reg == '0) && !culled_reg)
    `FBPC_ASSERT_NOW(a_plane_in_range, clk, rst_n, state_reg == ST_RUN,
        32'(plane_reg) < PLANE_COUNT)
    `FBPC_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == ST_DONE)
    `FBPC_ASSERT_NOW(a_no_issue_outside_run, clk, rst_n, prod_vld_reg,
        ($past(state_reg) == ST_RUN))

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the frustum culling core
`timescale 1ns / 1ps

module testbench import fbpc_pkg::*; ();

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic signed [COORD_BITS-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [COORD_BITS-1:0] MAXC = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_BITS-1:0] MINC = 32'sh8000_0000;
    localparam logic signed [COORD_BITS-1:0] NEG1 = 32'shFFFF_FFFF;

    localparam int RANDOM_TESTS = 2000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 40;

    typedef struct {
        logic [CMD_W-1:0]             command;
        logic [SLOT_W-1:0]            slot;
        logic signed [COORD_BITS-1:0] nx, ny, nz, ofs;
        logic signed [COORD_BITS-1:0] lx, ly, lz;
        logic signed [COORD_BITS-1:0] hx, hy, hz;
    } cull_req_t;

    // where the expected visible bit comes from
    typedef enum logic [1:0] {BY_MODEL, SEES_IT, CULLS_IT} cull_check_t;

    typedef struct {
        cull_req_t   req;
        cull_check_t how;
    } cull_row_t;

    logic clk;
    logic rst_n;

    fbpc_cmd_if cmd();
    fbpc_res_if res();

    frustum_box_point_cull_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    logic signed [COORD_BITS-1:0] plane_nx [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] plane_ny [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] plane_nz [PLANE_COUNT];
    logic signed [COORD_BITS-1:0] plane_ofs [PLANE_COUNT];

    logic      visible_due [$];
    cull_row_t directed_rows [$];
    int        failures;
    bit        send_burst;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [127:0] widen(input logic signed [COORD_BITS-1:0] v);
        return v;
    endfunction

    // nonnegative distance to every plane keeps the item
    function automatic logic predict_visible(input cull_req_t r);
        logic signed [COORD_BITS-1:0] px, py, pz;
        logic signed [127:0]          plane_dist;
        logic                         seen;
        seen = 1'b1;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            px = r.lx;
            py = r.ly;
            pz = r.lz;
            if (r.command == CMD_BOX)
            begin
                if (!plane_nx[i][COORD_BITS-1]) px = r.hx;
                if (!plane_ny[i][COORD_BITS-1]) py = r.hy;
                if (!plane_nz[i][COORD_BITS-1]) pz = r.hz;
            end
            plane_dist = widen(plane_nx[i]) * widen(px) + widen(plane_ny[i]) * widen(py)
                       + widen(plane_nz[i]) * widen(pz)
                       + (widen(plane_ofs[i]) <<< FRAC_BITS);
            if (plane_dist < 0) seen = 1'b0;
        end
        return seen;
    endfunction

    function automatic void note_transfer(input cull_req_t r, input cull_check_t how);
        case (r.command)
            CMD_LOAD:
            begin
                if (int'(r.slot) < PLANE_COUNT)
                begin
                    plane_nx[r.slot]  = r.nx;
                    plane_ny[r.slot]  = r.ny;
                    plane_nz[r.slot]  = r.nz;
                    plane_ofs[r.slot] = r.ofs;
                end
            end
            CMD_BOX, CMD_POINT:
            begin
                if (how == BY_MODEL)
                    visible_due = {visible_due, predict_visible(r)};
                else
                    visible_due = {visible_due, logic'(how == SEES_IT)};
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_req(input cull_req_t r, input cull_check_t how);
        int gap;
        if ($urandom_range(49) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.command      <= r.command;
        cmd.plane_slot   <= r.slot;
        cmd.normal_x     <= r.nx;
        cmd.normal_y     <= r.ny;
        cmd.normal_z     <= r.nz;
        cmd.plane_offset <= r.ofs;
        cmd.lo_x         <= r.lx;
        cmd.lo_y         <= r.ly;
        cmd.lo_z         <= r.lz;
        cmd.hi_x         <= r.hx;
        cmd.hi_y         <= r.hy;
        cmd.hi_z         <= r.hz;
        do @(posedge clk); while (cmd.ready !== 1'b1);
        note_transfer(r, how);
    endtask

    task automatic add_row(
        input logic [CMD_W-1:0]             c,
        input logic [SLOT_W-1:0]            s,
        input logic signed [COORD_BITS-1:0] nx, ny, nz, ofs,
        input logic signed [COORD_BITS-1:0] lx, ly, lz,
        input logic signed [COORD_BITS-1:0] hx, hy, hz,
        input cull_check_t                  how
    );
        cull_row_t row;
        row.req = '{c, s, nx, ny, nz, ofs, lx, ly, lz, hx, hy, hz};
        row.how = how;
        directed_rows = {directed_rows, row};
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_extreme();
        case ($urandom_range(5))
            0: return MINC;
            1: return MAXC;
            2: return 0;
            3: return NEG1;
            4: return ONE;
            default: return -ONE;
        endcase
    endfunction

    // mostly small values so that both outcomes stay common
    function automatic logic signed [COORD_BITS-1:0] rand_coord(input int span);
        case ($urandom_range(9))
            0: return pick_extreme();
            1: return $urandom;
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    function automatic cull_req_t rand_req();
        cull_req_t r;
        int        pick;
        r = '{CMD_W'($urandom), SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            r.command = CMD_LOAD;
            r.slot    = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(6, 7))
                                                 : SLOT_W'($urandom_range(0, 5));
            if ($urandom_range(9) == 0)
            begin
                r.nx = 0;
                r.ny = 0;
                r.nz = 0;
            end
            else
            begin
                r.nx = rand_coord(1 << 17);
                r.ny = rand_coord(1 << 17);
                r.nz = rand_coord(1 << 17);
            end
            case ($urandom_range(9))
                0: r.ofs = pick_extreme();
                1: r.ofs = $urandom;
                default: r.ofs = int'($urandom_range(0, 1 << 22)) - (1 << 18);
            endcase
        end
        else if (pick < 25)
            r.command = CMD_SPARE;
        else
        begin
            r.command = (pick < 65) ? CMD_BOX : CMD_POINT;
            r.lx = rand_coord(1 << 18);
            r.ly = rand_coord(1 << 18);
            r.lz = rand_coord(1 << 18);
            if (r.command == CMD_BOX && $urandom_range(9) != 0)
            begin
                r.hx = r.lx + int'($urandom_range(0, 1 << 18));
                r.hy = r.ly + int'($urandom_range(0, 1 << 18));
                r.hz = r.lz + int'($urandom_range(0, 1 << 18));
            end
        end
        return r;
    endfunction

    // result side: random stalls, checks each transfer in order
    initial
    begin
        int  stall;
        bit  burst;
        logic want;
        burst = 1'b0;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(49) == 0) burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (res.valid !== 1'b1);
            if (visible_due.size() == 0)
            begin
                $error("visible: unexpected result %0b with nothing expected", res.visible);
                failures++;
            end
            else
            begin
                want = visible_due.pop_front();
                if (res.visible !== want)
                begin
                    $error("visible: expected %0b, actual %0b", want, res.visible);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        cull_req_t r;
        int        tests;
        int        waited;
        failures   = 0;
        send_burst = 1'b0;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            plane_nx[i]  = 0;
            plane_ny[i]  = 0;
            plane_nz[i]  = 0;
            plane_ofs[i] = 0;
        end
        rst_n            <= 1'b0;
        cmd.valid        <= 1'b0;
        cmd.command      <= CMD_LOAD;
        cmd.plane_slot   <= '0;
        cmd.normal_x     <= '0;
        cmd.normal_y     <= '0;
        cmd.normal_z     <= '0;
        cmd.plane_offset <= '0;
        cmd.lo_x         <= '0;
        cmd.lo_y         <= '0;
        cmd.lo_z         <= '0;
        cmd.hi_x         <= '0;
        cmd.hi_y         <= '0;
        cmd.hi_z         <= '0;

        // empty planes never cull
        add_row(CMD_POINT, 0, 0, 0, 0, 0, MINC, MAXC, MINC, 0, 0, 0, SEES_IT);
        add_row(CMD_BOX, 0, 0, 0, 0, 0, MINC, MINC, MINC, MAXC, MAXC, MAXC, SEES_IT);
        // spare command and out-of-range slots leave the planes alone
        add_row(CMD_SPARE, 7, NEG1, NEG1, NEG1, MINC, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1,
                BY_MODEL);
        add_row(CMD_LOAD, 6, 0, 0, 0, MINC, 0, 0, 0, 0, 0, 0, BY_MODEL);
        add_row(CMD_LOAD, 7, NEG1, 0, 0, MINC, 0, 0, 0, 0, 0, 0, BY_MODEL);
        add_row(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, SEES_IT);
        // negative offset alone culls everything
        add_row(CMD_LOAD, 0, 0, 0, 0, NEG1, 0, 0, 0, 0, 0, 0, BY_MODEL);
        add_row(CMD_POINT, 0, 0, 0, 0, 0, MAXC, MAXC, MAXC, 0, 0, 0, CULLS_IT);
        // x >= 0 half space, unused fields full of junk
        add_row(CMD_LOAD, 0, ONE, 0, 0, 0, NEG1, MINC, MAXC, NEG1, MINC, MAXC, BY_MODEL);
        add_row(CMD_POINT, 0, MAXC, MAXC, MAXC, MINC, -ONE, 0, 0, MAXC, 0, 0, CULLS_IT);
        add_row(CMD_POINT, 5, NEG1, NEG1, NEG1, NEG1, 0, MINC, MAXC, MINC, MINC, MINC,
                SEES_IT);
        add_row(CMD_BOX, 0, 0, 0, 0, 0, -5 * ONE, 0, 0, 5 * ONE, 0, 0, BY_MODEL);
        // inverted box: corners used as given
        add_row(CMD_BOX, 0, 0, 0, 0, 0, 5 * ONE, 0, 0, -5 * ONE, 0, 0, BY_MODEL);
        add_row(CMD_LOAD, 1, -ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, BY_MODEL);
        add_row(CMD_BOX, 0, 0, 0, 0, 0, -ONE, 0, 0, ONE, 0, 0, BY_MODEL);
        add_row(CMD_BOX, 0, 0, 0, 0, 0, 2 * ONE, 0, 0, 3 * ONE, 0, 0, BY_MODEL);
        // extreme planes against extreme corners
        add_row(CMD_LOAD, 2, MINC, MINC, MINC, MAXC, 0, 0, 0, 0, 0, 0, BY_MODEL);
        add_row(CMD_LOAD, 3, MAXC, MAXC, MAXC, MINC, 0, 0, 0, 0, 0, 0, BY_MODEL);
        add_row(CMD_BOX, 0, 0, 0, 0, 0, MINC, MINC, MINC, MAXC, MAXC, MAXC, BY_MODEL);
        add_row(CMD_POINT, 0, 0, 0, 0, 0, MAXC, MAXC, MAXC, 0, 0, 0, BY_MODEL);
        add_row(CMD_POINT, 0, 0, 0, 0, 0, MINC, MINC, MINC, 0, 0, 0, BY_MODEL);
        add_row(CMD_LOAD, 5, 0, 0, ONE, ONE, 0, 0, 0, 0, 0, 0, BY_MODEL);
        add_row(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, -2 * ONE, 0, 0, 0, BY_MODEL);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].how);

        // hold off until the pipeline has emptied
        cmd.valid <= 1'b0;
        wait (visible_due.size() == 0);

        tests = 0;
        while (tests < RANDOM_TESTS)
        begin
            if (tests == RANDOM_TESTS / 2)
            begin
                cmd.valid <= 1'b0;
                wait (visible_due.size() == 0);
            end
            r = rand_req();
            send_req(r, BY_MODEL);
            if (r.command == CMD_BOX || r.command == CMD_POINT ||
                (r.command == CMD_LOAD && int'(r.slot) < PLANE_COUNT))
                tests++;
        end
        cmd.valid <= 1'b0;

        waited = 0;
        while (visible_due.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (visible_due.size() > 0)
        begin
            $error("visible: %0d expected results never arrived", visible_due.size());
            failures += visible_due.size();
        end
        repeat (SETTLE) @(posedge clk);

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
